@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Widths, reset values, operation codes and status codes of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_MAX_BLOCKS = 8192;
    localparam int DEF_WORD_BITS  = 32;

    localparam int TOTAL_W  = 14;
    localparam int BLOCK_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 14'd8192;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } status_t;

endpackage

@@ hdl/block_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a usage bitmap held in an internal word memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields
//  s_*       in         s_tuser: operation; s_tdata: block_number (13 bits)
//  m_*       out        m_tuser: status; m_tdata: result_block (13 bits)
//  cfg_*     in         cfg_data: total_blocks
//
// An allocate walks the bitmap one word per cycle up to the first word
// holding a free block. A free walks to the block's word one word per cycle,
// then reads and writes it. A range error goes to the result without a walk.
// After reset the bitmap memory is cleared word by word (NUM_WORDS words, 256
// by default) before the first transaction is accepted.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits for the register only at its end.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [12:0] block_number, [15:13] zero
    input  logic [0:0]         s_tuser,   // [0] operation

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [12:0] result_block, [15:13] zero
    output logic [STATUS_W-1:0] m_tuser,  // [1:0] status

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TOTAL_W-1:0] cfg_data   // [13:0] total_blocks
);

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int SPAN_W    = $clog2(MAX_BLOCKS + 2 * WORD_BITS);
    localparam int CNT_W     = (SPAN_W > TOTAL_W) ? SPAN_W : TOTAL_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SEEK  = 7'b0001000,
        S_FCHK  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_START = 7'b1000000
    } state_t;

    logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];

    state_t               state_reg, state_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]    iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]     iss_base_reg, iss_base_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]    chk_addr_reg, chk_addr_next;
    logic [CNT_W-1:0]     chk_base_reg, chk_base_next;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 op_reg, op_next;
    logic [BLOCK_W-1:0]   req_reg, req_next;
    logic [BLOCK_W-1:0]   res_blk_reg, res_blk_next;
    status_t              res_st_reg, res_st_next;
    logic                 m_valid_reg, m_valid_next;
    logic [BLOCK_W-1:0]   out_blk_reg, out_blk_next;
    status_t              out_st_reg, out_st_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [CNT_W-1:0]     total_ext;
    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     req_ext;
    logic [CNT_W-1:0]     span;
    logic [WORD_BITS-1:0] free_bits;
    logic                 free_any;
    logic [OFF_W-1:0]     free_idx;
    logic [OFF_W-1:0]     off;

    assign total_ext = CNT_W'(total_reg);
    assign limit     = (total_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_ext;
    assign req_ext   = CNT_W'(req_reg);
    assign span      = limit - chk_base_reg;
    assign off       = OFF_W'(req_ext - iss_base_reg);

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = !rd_data_reg[i] && (CNT_W'(i) < span);
        end
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = OFF_W'(i);
                free_any = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[iss_addr_reg];
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        iss_addr_next  = iss_addr_reg;
        iss_base_next  = iss_base_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        chk_base_next  = chk_base_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        res_blk_next   = res_blk_reg;
        res_st_next    = res_st_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_blk_next   = out_blk_reg;
        out_st_next    = out_st_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_addr_reg;
        wr_data        = '0;

        case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(NUM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser[0];
                    req_next   = s_tdata[BLOCK_W-1:0];
                    state_next = S_START;
                end
            end
            S_START: begin
                iss_addr_next = '0;
                iss_base_next = '0;
                res_blk_next  = '0;
                if (op_reg == OP_ALLOC) begin
                    if (limit == '0) begin
                        res_st_next = ST_FULL;
                        state_next  = S_EMIT;
                    end else begin
                        state_next  = S_SCAN;
                    end
                end else begin
                    if (req_ext >= limit) begin
                        res_st_next = ST_RANGE;
                        state_next  = S_EMIT;
                    end else begin
                        state_next  = S_SEEK;
                    end
                end
            end
            S_SCAN: begin
                if (iss_base_reg < limit) begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = iss_addr_reg;
                    chk_base_next  = iss_base_reg;
                    iss_addr_next  = iss_addr_reg + 1'b1;
                    iss_base_next  = iss_base_reg + CNT_W'(WORD_BITS);
                end
                if (chk_valid_reg) begin
                    if (free_any) begin
                        wr_en          = 1'b1;
                        wr_addr        = chk_addr_reg;
                        wr_data        = rd_data_reg | (WORD_BITS'(1) << free_idx);
                        res_blk_next   = BLOCK_W'(chk_base_reg + CNT_W'(free_idx));
                        res_st_next    = ST_OK;
                        chk_valid_next = 1'b0;
                        state_next     = S_EMIT;
                    end else if (span <= CNT_W'(WORD_BITS)) begin
                        res_blk_next   = '0;
                        res_st_next    = ST_FULL;
                        chk_valid_next = 1'b0;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_SEEK: begin
                if (req_ext < iss_base_reg + CNT_W'(WORD_BITS)) begin
                    state_next = S_FCHK;
                end else begin
                    iss_addr_next = iss_addr_reg + 1'b1;
                    iss_base_next = iss_base_reg + CNT_W'(WORD_BITS);
                end
            end
            S_FCHK: begin
                if (!rd_data_reg[off]) begin
                    res_blk_next = '0;
                    res_st_next  = ST_ALREADY_FREE;
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = iss_addr_reg;
                    wr_data      = rd_data_reg & ~(WORD_BITS'(1) << off);
                    res_blk_next = req_reg;
                    res_st_next  = ST_OK;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_blk_next = res_blk_reg;
                    out_st_next  = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            total_reg     <= TOTAL_RESET;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                total_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        iss_addr_reg <= iss_addr_next;
        iss_base_reg <= iss_base_next;
        chk_addr_reg <= chk_addr_next;
        chk_base_reg <= chk_base_next;
        op_reg       <= op_next;
        req_reg      <= req_next;
        res_blk_reg  <= res_blk_next;
        res_st_reg   <= res_st_next;
        out_blk_reg  <= out_blk_next;
        out_st_reg   <= out_st_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(16 - BLOCK_W){1'b0}}, out_blk_reg};
    assign m_tuser   = out_st_reg;

endmodule

@@ tb/block_bitmap_allocator_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Watches the request, result and count channels of the allocator, keeps its
// own usage map and block count, works out the grant for each accepted
// request and compares every accepted result with the oldest grant due.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_chk
    import bba_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [15:0]         s_tdata,   // [12:0] block_number, [15:13] zero
    input  logic [0:0]          s_tuser,   // [0] operation

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [15:0]         m_tdata,   // [12:0] result_block, [15:13] zero
    input  logic [STATUS_W-1:0] m_tuser,   // [1:0] status

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TOTAL_W-1:0]  cfg_data,  // [13:0] total_blocks

    output int                  fail_count,
    output int                  outstanding
);

    localparam int MAX_BLOCKS = DEF_MAX_BLOCKS;

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        status_t            status;
    } grant_t;

    logic [MAX_BLOCKS-1:0] in_use;
    logic [TOTAL_W-1:0]    block_count;
    grant_t                grants_due[$];

    function automatic int active_blocks();
        return (int'(block_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
    endfunction

    // First fit for an allocate, a checked clear for a free; the usage map
    // is only touched when the status is ok.
    function automatic grant_t grant_block(input op_t op, input logic [BLOCK_W-1:0] req);
        grant_t g;
        int     limit;
        limit = active_blocks();
        g.blk = '0;
        if (op == OP_ALLOC) begin
            g.status = ST_FULL;
            for (int b = 0; b < limit; b++) begin
                if (!in_use[b]) begin
                    in_use[b] = 1'b1;
                    g.blk     = BLOCK_W'(b);
                    g.status  = ST_OK;
                    break;
                end
            end
        end else if (int'(req) >= limit) begin
            g.status = ST_RANGE;
        end else if (!in_use[req]) begin
            g.status = ST_ALREADY_FREE;
        end else begin
            in_use[req] = 1'b0;
            g.blk       = req;
            g.status    = ST_OK;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            in_use      = '0;
            block_count = TOTAL_RESET;
            grants_due.delete();
            fail_count  = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                block_count = cfg_data;
            if (m_tvalid && m_tready) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("result with no request waiting", int'(m_tdata), -1);
                end else begin
                    want = grants_due.pop_front();
                    if (m_tdata != {3'b000, want.blk})
                        report_mismatch("result_block", int'(m_tdata), int'(want.blk));
                    if (m_tuser != want.status)
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(grant_block(op_t'(s_tuser[0]), s_tdata[BLOCK_W-1:0]));
            outstanding <= grants_due.size();
        end
    end

endmodule

@@ tb/block_bitmap_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives allocate and free requests through a directed opening and a long
// random run over several block counts, with random gaps on both channels
// and one long result stall; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_tb;
    import bba_pkg::*;

    localparam int RX_HOLD_CYCLES = 1500;
    localparam int CYCLE_LIMIT    = 4000000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASES         = 20;
    localparam int PHASE_ITEMS    = 95;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;

    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;

    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TOTAL_W-1:0]  cfg_data  = TOTAL_RESET;

    int                  fail_count;
    int                  outstanding;
    int                  cycle_count = 0;
    int                  blocks_now  = DEF_MAX_BLOCKS;
    int                  rx_gap      = 0;
    int                  rx_draw;
    logic                calm        = 1'b0;
    logic                rx_hold     = 1'b0;
    logic                stall_go    = 1'b0;

    block_bitmap_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    block_bitmap_allocator_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            rx_draw = calm ? 0 : $urandom_range(0, 7);
            m_tready <= (rx_draw == 0);
            rx_gap   <= rx_draw;
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : rx_pressure
        wait (stall_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    task automatic send_item(input op_t op, input logic [BLOCK_W-1:0] blk);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, blk};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // The count is only changed once every result has been taken.
    task automatic write_count(input logic [TOTAL_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        blocks_now = (int'(value) > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(value);
    endtask

    // Frees mostly aim at the low blocks that allocation fills first, some
    // at the edge of the active count, the rest anywhere.
    task automatic random_item();
        op_t                op;
        logic [BLOCK_W-1:0] blk;
        int                 win;
        int                 pick;
        int                 near;
        op   = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
        win  = (blocks_now < 1) ? 1 : ((blocks_now > 128) ? 128 : blocks_now);
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            blk = BLOCK_W'($urandom_range(0, win - 1));
        end else if (pick < 75) begin
            near = blocks_now - 2 + int'($urandom_range(0, 3));
            if (near < 0)
                near = 0;
            if (near > 8191)
                near = 8191;
            blk = BLOCK_W'(near);
        end else begin
            blk = BLOCK_W'($urandom_range(0, 8191));
        end
        send_item(op, blk);
    endtask

    initial begin : stimulus
        logic [TOTAL_W-1:0] count_sel;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(OP_ALLOC, 13'h1FFF);
        send_item(OP_ALLOC, 13'd0);
        send_item(OP_FREE,  13'd1);
        send_item(OP_FREE,  13'd1);
        send_item(OP_FREE,  13'h1FFF);
        send_item(OP_ALLOC, 13'd0);

        write_count(14'd0);
        send_item(OP_ALLOC, 13'd0);
        send_item(OP_FREE,  13'd0);

        write_count(14'd1);
        send_item(OP_ALLOC, 13'd5);
        send_item(OP_FREE,  13'd1);
        send_item(OP_FREE,  13'd0);
        send_item(OP_ALLOC, 13'd0);
        send_item(OP_ALLOC, 13'd0);

        write_count(14'h3FFF);
        send_item(OP_FREE,  13'h1FFF);
        send_item(OP_ALLOC, 13'h0AAA);
        send_item(OP_FREE,  13'd1);

        write_count(14'd8191);
        send_item(OP_FREE,  13'h1FFF);
        send_item(OP_FREE,  13'h1FFE);
        send_item(OP_ALLOC, 13'h1555);

        for (int p = 0; p < PHASES; p++) begin
            case (p % 8)
                0:       count_sel = 14'd1;
                1:       count_sel = TOTAL_W'($urandom_range(2, 40));
                2:       count_sel = 14'd8192;
                3:       count_sel = TOTAL_W'($urandom_range(33, 200));
                4:       count_sel = 14'd0;
                5:       count_sel = 14'h3FFF;
                6:       count_sel = TOTAL_W'($urandom_range(0, 16383));
                default: count_sel = TOTAL_W'($urandom_range(1, 64));
            endcase
            write_count(count_sel);
            calm <= ($urandom_range(0, 3) == 0);
            if (p == 1)
                stall_go <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
